// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under a clock and an active-low reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under a clock and an active-low reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants of the I2C master transaction engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// width of the byte counter
	localparam int COUNT_WIDTH = 16;

	// transaction kinds
	localparam logic [1:0] KIND_WRITE     = 2'd0;
	localparam logic [1:0] KIND_READ      = 2'd1;
	localparam logic [1:0] KIND_REG_WRITE = 2'd2;
	localparam logic [1:0] KIND_REG_READ  = 2'd3;

	// completion status
	localparam logic [1:0] STATUS_GOOD     = 2'd0;
	localparam logic [1:0] STATUS_BUS_BUSY = 2'd1;
	localparam logic [1:0] STATUS_NACK     = 2'd2;

	// address byte direction bit
	localparam logic [7:0] ADDR_RD_MASK = 8'h01;
	localparam logic [7:0] ADDR_WR_MASK = 8'hFE;

	// one tick word as it arrives
	typedef struct packed {
		logic        begin_req;
		logic [1:0]  kind;
		logic [6:0]  device_addr;
		logic [7:0]  reg_addr;
		logic [15:0] byte_count;
		logic        ack_level;
		logic [7:0]  tx_data;
		logic        sda_in;
	} req_word_t;

	// one tick result word
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       byte_taken;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       done_res;
		logic [1:0] status;
	} res_word_t;

	// decoded transaction kind
	typedef struct packed {
		logic plain_read;
		logic has_reg;
		logic reg_read;
	} kind_class_t;

	// classified tick as held in the queue
	typedef struct packed {
		logic                   begin_req;
		kind_class_t            kclass;
		logic [6:0]             device_addr;
		logic [7:0]             reg_addr;
		logic [COUNT_WIDTH-1:0] count;
		logic                   ack_level;
		logic [7:0]             tx_data;
		logic                   sda_in;
	} entry_t;

	// queue head toward the engine
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage

// ----- rtl/i2cm_front.sv -----
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts tick words, decodes the transaction kind and queues them (2 deep).
// ----------------------------------------------------------------------------
module i2cm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  i2cm_pkg::req_word_t  req_word,
	output i2cm_pkg::head_t      head,
	input  logic                 head_pop
);

	i2cm_pkg::entry_t      slots_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	i2cm_pkg::entry_t      cls;
	logic                  push;
	logic                  pop;

	// kind decode and count truncation
	always_comb begin
		cls.begin_req   = req_word.begin_req;
		cls.device_addr = req_word.device_addr;
		cls.reg_addr    = req_word.reg_addr;
		cls.count       = req_word.byte_count[i2cm_pkg::COUNT_WIDTH-1:0];
		cls.ack_level   = req_word.ack_level;
		cls.tx_data     = req_word.tx_data;
		cls.sda_in      = req_word.sda_in;
		cls.kclass      = '0;
		unique case (req_word.kind)
			i2cm_pkg::KIND_WRITE: begin
				cls.kclass = '0;
			end
			i2cm_pkg::KIND_READ: begin
				cls.kclass.plain_read = 1'b1;
			end
			i2cm_pkg::KIND_REG_WRITE: begin
				cls.kclass.has_reg = 1'b1;
			end
			i2cm_pkg::KIND_REG_READ: begin
				cls.kclass.has_reg  = 1'b1;
				cls.kclass.reg_read = 1'b1;
			end
			default: begin
				cls.kclass = '0;
			end
		endcase
	end

	assign req_ready  = (count_q != 2'd2);
	assign push       = req_valid && req_ready;
	assign pop        = head_pop && (count_q != 2'd0);
	assign head.valid = (count_q != 2'd0);
	assign head.entry = slots_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/i2cm_back.sv -----
// ----------------------------------------------------------------------------
// i2cm_back
// Bus sequencer: advances the transaction one tick per queued word and
// registers the result word.
// ----------------------------------------------------------------------------
module i2cm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cm_pkg::head_t      head,
	output logic                 head_pop,
	output logic                 res_valid,
	input  logic                 res_ready,
	output i2cm_pkg::res_word_t  res_word
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C,
		PH_WB0, PH_WB1, PH_WB2, PH_WA0, PH_WA1,
		PH_RPRE, PH_RHI, PH_RLO, PH_RA0, PH_RA1, PH_RA2,
		PH_SP0, PH_SP1, PH_SP2, PH_SP3
	} phase_t;

	typedef enum logic [1:0] {
		STG_ADDR1, STG_REG, STG_ADDR2, STG_DATA
	} stage_t;

	localparam logic [i2cm_pkg::COUNT_WIDTH-1:0] CNT_ONE =
		{{(i2cm_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};

	phase_t                           phase_q, ph_n, ph_c;
	stage_t                           stage_q, stg_n, stg_c;
	logic [2:0]                       bit_q, bit_n;
	logic [7:0]                       shift_q, shift_n;
	logic [i2cm_pkg::COUNT_WIDTH-1:0] left_q, left_n, left_c;
	i2cm_pkg::kind_class_t            kind_q, kind_n;
	logic [6:0]                       dev_q, dev_n;
	logic [7:0]                       reg_q, reg_n;
	logic                             ack_q, ack_n;
	logic [1:0]                       lines_q;
	logic                             nack_q, nack_n;
	logic                             res_valid_q;
	i2cm_pkg::res_word_t              res_q, res_n;
	logic                             take;
	logic                             ack_lvl;
	logic                             scl, sda;
	i2cm_pkg::entry_t                 e;

	assign e        = head.entry;
	assign take     = head.valid && (!res_valid_q || res_ready);
	assign head_pop = take;
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	// one bus tick of the sequencer
	always_comb begin
		ph_c   = phase_q;
		stg_c  = stage_q;
		left_c = left_q;
		kind_n = kind_q;
		dev_n  = dev_q;
		reg_n  = reg_q;
		ack_n  = ack_q;
		nack_n = nack_q;
		// begin is taken on the first start tick
		if (phase_q == PH_IDLE && e.begin_req) begin
			kind_n = e.kclass;
			dev_n  = e.device_addr;
			reg_n  = e.reg_addr;
			left_c = e.count;
			ack_n  = e.ack_level;
			stg_c  = STG_ADDR1;
			nack_n = 1'b0;
			ph_c   = PH_ST_A;
		end
		ph_n    = ph_c;
		stg_n   = stg_c;
		left_n  = left_c;
		bit_n   = bit_q;
		shift_n = shift_q;
		scl     = 1'b1;
		sda     = 1'b1;
		res_n   = '0;
		res_n.busy_res = 1'b1;
		res_n.status   = i2cm_pkg::STATUS_GOOD;
		// level sent in the read ack slot, nack on the last byte
		ack_lvl = (left_c == '0) ? 1'b1 : (kind_n.plain_read ? ack_n : 1'b0);

		unique case (ph_c)
			PH_ST_A: begin
				if (!e.sda_in) begin
					res_n.done_res = 1'b1;
					res_n.status   = i2cm_pkg::STATUS_BUS_BUSY;
					ph_n = PH_IDLE;
				end else begin
					ph_n = PH_ST_B;
				end
			end
			PH_ST_B: begin
				sda  = 1'b0;
				ph_n = PH_ST_C;
			end
			PH_ST_C: begin
				scl = 1'b0;
				sda = 1'b0;
				if (stg_c == STG_ADDR2 || kind_n.plain_read) begin
					shift_n = {dev_n, 1'b0} | i2cm_pkg::ADDR_RD_MASK;
				end else begin
					shift_n = {dev_n, 1'b0} & i2cm_pkg::ADDR_WR_MASK;
				end
				bit_n = 3'd7;
				ph_n  = PH_WB0;
			end
			PH_WB0: begin
				if (stg_c == STG_DATA && bit_q == 3'd7) begin
					shift_n = e.tx_data;
					res_n.byte_taken = 1'b1;
					left_n = left_c - CNT_ONE;
				end
				scl  = 1'b0;
				sda  = shift_n[7];
				ph_n = PH_WB1;
			end
			PH_WB1: begin
				sda  = shift_q[7];
				ph_n = PH_WB2;
			end
			PH_WB2: begin
				scl     = 1'b0;
				sda     = shift_q[7];
				shift_n = {shift_q[6:0], 1'b0};
				if (bit_q == 3'd0) begin
					ph_n = PH_WA0;
				end else begin
					bit_n = bit_q - 3'd1;
					ph_n  = PH_WB0;
				end
			end
			PH_WA0: begin
				scl  = 1'b0;
				ph_n = PH_WA1;
			end
			PH_WA1: begin
				// ack slot decides the next byte
				if (e.sda_in) begin
					nack_n = 1'b1;
					ph_n   = PH_SP0;
				end else if (stg_c == STG_ADDR1 && kind_n.plain_read) begin
					stg_n = STG_DATA;
					ph_n  = (left_c != '0) ? PH_RPRE : PH_SP0;
				end else if (stg_c == STG_ADDR1 && kind_n.has_reg) begin
					stg_n   = STG_REG;
					shift_n = reg_n;
					bit_n   = 3'd7;
					ph_n    = PH_WB0;
				end else if (stg_c == STG_REG && kind_n.reg_read) begin
					stg_n = STG_ADDR2;
					ph_n  = PH_ST_A;
				end else if (stg_c == STG_ADDR2) begin
					stg_n = STG_DATA;
					ph_n  = (left_c != '0) ? PH_RPRE : PH_SP0;
				end else begin
					stg_n = STG_DATA;
					if (left_c != '0) begin
						bit_n = 3'd7;
						ph_n  = PH_WB0;
					end else begin
						ph_n = PH_SP0;
					end
				end
			end
			PH_RPRE: begin
				scl     = 1'b0;
				left_n  = left_c - CNT_ONE;
				shift_n = '0;
				bit_n   = 3'd7;
				ph_n    = PH_RHI;
			end
			PH_RHI: begin
				shift_n = {shift_q[6:0], e.sda_in};
				if (bit_q == 3'd0) begin
					res_n.rx_valid = 1'b1;
					res_n.rx_data  = shift_n;
				end
				ph_n = PH_RLO;
			end
			PH_RLO: begin
				scl = 1'b0;
				if (bit_q == 3'd0) begin
					ph_n = PH_RA0;
				end else begin
					bit_n = bit_q - 3'd1;
					ph_n  = PH_RHI;
				end
			end
			PH_RA0: begin
				scl  = 1'b0;
				sda  = ack_lvl;
				ph_n = PH_RA1;
			end
			PH_RA1: begin
				sda  = ack_lvl;
				ph_n = PH_RA2;
			end
			PH_RA2: begin
				scl  = 1'b0;
				sda  = ack_lvl;
				ph_n = (left_c != '0) ? PH_RPRE : PH_SP0;
			end
			PH_SP0: begin
				scl  = 1'b0;
				ph_n = PH_SP1;
			end
			PH_SP1: begin
				scl  = 1'b0;
				sda  = 1'b0;
				ph_n = PH_SP2;
			end
			PH_SP2: begin
				sda  = 1'b0;
				ph_n = PH_SP3;
			end
			PH_SP3: begin
				res_n.done_res = 1'b1;
				res_n.status   = nack_n ? i2cm_pkg::STATUS_NACK : i2cm_pkg::STATUS_GOOD;
				ph_n = PH_IDLE;
			end
			default: begin
				// idle: hold the last line levels
				ph_n = PH_IDLE;
				res_n.busy_res = 1'b0;
				scl = lines_q[1];
				sda = lines_q[0];
			end
		endcase
		res_n.scl_out = scl;
		res_n.sda_out = sda;
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			stage_q     <= STG_ADDR1;
			bit_q       <= 3'd0;
			shift_q     <= 8'h00;
			left_q      <= '0;
			kind_q      <= '0;
			dev_q       <= 7'd0;
			reg_q       <= 8'h00;
			ack_q       <= 1'b0;
			lines_q     <= 2'b11;
			nack_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (take) begin
				phase_q <= ph_n;
				stage_q <= stg_n;
				bit_q   <= bit_n;
				shift_q <= shift_n;
				left_q  <= left_n;
				kind_q  <= kind_n;
				dev_q   <= dev_n;
				reg_q   <= reg_n;
				ack_q   <= ack_n;
				lines_q <= {res_n.scl_out, res_n.sda_out};
				nack_q  <= nack_n;
				res_q   <= res_n;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/i2c_master_transaction_engine.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine
// I2C master with 7-bit addressing, run one bus delay tick per word.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_word (i2cm_pkg::req_word_t)
//   res     | out       | res_valid / res_ready | res_word (i2cm_pkg::res_word_t)
//
// One tick word in gives exactly one result word out.
// Throughput is one word per cycle while res_ready is high; a word passes
// through the queue, then the sequencer step that writes the result register.
// A two-entry queue sits between the front and the sequencer; with the
// result register up to three words can be held while res_ready is low.
// arst_n clears the queue, the result register and the sequencer to idle.
// ----------------------------------------------------------------------------
module i2c_master_transaction_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  i2cm_pkg::req_word_t  req_word,
	output logic                 res_valid,
	input  logic                 res_ready,
	output i2cm_pkg::res_word_t  res_word
);

	i2cm_pkg::head_t head;
	logic            head_pop;

	// accept and decode
	i2cm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.head      (head),
		.head_pop  (head_pop)
	);

	// bus sequencer
	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_pop  (head_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

// ----- rtl/i2cm_checker.sv -----
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master transaction engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input i2cm_pkg::res_word_t  res_word
);

	logic res_stall;
	logic no_done;
	logic status_set;
	logic idle_word;
	logic idle_quiet;
	logic tx_rx_both;

	// conditions seen on the result port
	assign res_stall  = res_valid && !res_ready;
	assign no_done    = res_valid && !res_word.done_res;
	assign status_set = (res_word.status != i2cm_pkg::STATUS_GOOD);
	assign idle_word  = res_valid && !res_word.busy_res;
	assign idle_quiet = res_word.scl_out && res_word.sda_out && !res_word.byte_taken
		&& !res_word.rx_valid && !res_word.done_res;
	assign tx_rx_both = res_word.byte_taken && res_word.rx_valid;

	// stalled result word holds
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, $stable({res_valid, res_word}), "stall lost")

	// status only reported with done
	`ASSERT_IMPLIES(a_status_done, clk, arst_n, no_done, !status_set, "status without done")

	// idle words release both lines and flag nothing
	`ASSERT_IMPLIES(a_idle_quiet, clk, arst_n, idle_word, idle_quiet, "idle word not quiet")

	// a tick never both takes a tx byte and delivers an rx byte
	`ASSERT_IMPLIES(a_tx_rx_excl, clk, arst_n, res_valid, !tx_rx_both, "taken and received")

endmodule

bind i2c_master_transaction_engine i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_word  (res_word)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Runs the I2C master engine one bus tick per word. A target model picks SDA
// for each tick from the predicted sequencer phase, a tick-level predictor
// works out the result word of every accepted tick, and each returned word
// is compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RANDOM_WORDS   = 150;
	localparam int MAX_WAIT       = 12;

	// sequencer phases as the predictor tracks them
	typedef enum logic [4:0] {
		T_IDLE, T_START_SAMPLE, T_START_LOW, T_START_CLK,
		T_BIT_SET, T_BIT_HIGH, T_BIT_HOLD, T_ACK_REL, T_ACK_SAMPLE,
		T_RD_LEAD, T_RD_HIGH, T_RD_LOW, T_RA_SET, T_RA_HIGH, T_RA_HOLD,
		T_STOP_REL, T_STOP_LOW, T_STOP_CLK, T_STOP_END
	} bus_phase_t;

	// which byte of the transaction is on the bus
	typedef enum logic [1:0] {SEG_ADDR, SEG_REG, SEG_READDR, SEG_DATA} segment_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	i2cm_pkg::req_word_t req_word  = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	i2cm_pkg::res_word_t res_word;

	// predictor state
	bus_phase_t                       bus_phase = T_IDLE;
	segment_t                         seg       = SEG_ADDR;
	logic [2:0]                       bit_pos   = '0;
	logic [7:0]                       shifter   = '0;
	logic [i2cm_pkg::COUNT_WIDTH-1:0] left_bytes = '0;
	logic [1:0]                       kind_q    = '0;
	logic [6:0]                       dev_q     = '0;
	logic [7:0]                       reg_q     = '0;
	logic                             ack_q     = 1'b0;
	logic [1:0]                       lines_q   = 2'b11;
	logic                             nack_q    = 1'b0;

	i2cm_pkg::res_word_t bus_words_due[$];
	int unsigned         words_sent = 0;
	int unsigned         failures   = 0;
	int unsigned         idle_cycles = 0;
	bit                  calm = 1'b0;

	i2c_master_transaction_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// predictor helpers
	function automatic void load_byte(logic [7:0] value);
		shifter   = value;
		bit_pos   = 3'd7;
		bus_phase = T_BIT_SET;
	endfunction

	function automatic void write_data();
		seg = SEG_DATA;
		if (left_bytes != 0) begin
			bit_pos   = 3'd7;
			bus_phase = T_BIT_SET;
		end else begin
			bus_phase = T_STOP_REL;
		end
	endfunction

	function automatic void read_data();
		seg       = SEG_DATA;
		bus_phase = (left_bytes != 0) ? T_RD_LEAD : T_STOP_REL;
	endfunction

	// random bits over the whole input word
	function automatic i2cm_pkg::req_word_t random_word();
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		return noise[$bits(i2cm_pkg::req_word_t)-1:0];
	endfunction

	// advance the predicted sequencer by one tick and return its result word
	function automatic i2cm_pkg::res_word_t bus_tick(i2cm_pkg::req_word_t w);
		i2cm_pkg::res_word_t r;
		logic                ack_bit;
		r          = '0;
		r.scl_out  = 1'b1;
		r.sda_out  = 1'b1;
		r.busy_res = 1'b1;
		if (bus_phase == T_IDLE && w.begin_req) begin
			kind_q     = w.kind;
			dev_q      = w.device_addr;
			reg_q      = w.reg_addr;
			left_bytes = w.byte_count[i2cm_pkg::COUNT_WIDTH-1:0];
			ack_q      = w.ack_level;
			seg        = SEG_ADDR;
			nack_q     = 1'b0;
			bus_phase  = T_START_SAMPLE;
		end
		ack_bit = (left_bytes == 0) ? 1'b1
			: ((kind_q == i2cm_pkg::KIND_READ) ? ack_q : 1'b0);
		case (bus_phase)
			T_START_SAMPLE: begin
				if (!w.sda_in) begin
					r.done_res = 1'b1;
					r.status   = i2cm_pkg::STATUS_BUS_BUSY;
					bus_phase  = T_IDLE;
				end else begin
					bus_phase = T_START_LOW;
				end
			end
			T_START_LOW: begin
				r.sda_out = 1'b0;
				bus_phase = T_START_CLK;
			end
			T_START_CLK: begin
				r.scl_out = 1'b0;
				r.sda_out = 1'b0;
				if (seg == SEG_READDR || kind_q == i2cm_pkg::KIND_READ)
					load_byte({dev_q, 1'b0} | i2cm_pkg::ADDR_RD_MASK);
				else
					load_byte({dev_q, 1'b0} & i2cm_pkg::ADDR_WR_MASK);
			end
			T_BIT_SET: begin
				if (seg == SEG_DATA && bit_pos == 3'd7) begin
					shifter      = w.tx_data;
					r.byte_taken = 1'b1;
					left_bytes   = left_bytes - 1'b1;
				end
				r.scl_out = 1'b0;
				r.sda_out = shifter[7];
				bus_phase = T_BIT_HIGH;
			end
			T_BIT_HIGH: begin
				r.sda_out = shifter[7];
				bus_phase = T_BIT_HOLD;
			end
			T_BIT_HOLD: begin
				r.scl_out = 1'b0;
				r.sda_out = shifter[7];
				shifter   = shifter << 1;
				if (bit_pos == 3'd0) begin
					bus_phase = T_ACK_REL;
				end else begin
					bit_pos   = bit_pos - 1'b1;
					bus_phase = T_BIT_SET;
				end
			end
			T_ACK_REL: begin
				r.scl_out = 1'b0;
				bus_phase = T_ACK_SAMPLE;
			end
			T_ACK_SAMPLE: begin
				if (w.sda_in) begin
					nack_q    = 1'b1;
					bus_phase = T_STOP_REL;
				end else begin
					case (seg)
						SEG_ADDR: begin
							if (kind_q == i2cm_pkg::KIND_WRITE)
								write_data();
							else if (kind_q == i2cm_pkg::KIND_READ)
								read_data();
							else begin
								seg = SEG_REG;
								load_byte(reg_q);
							end
						end
						SEG_REG: begin
							if (kind_q == i2cm_pkg::KIND_REG_READ) begin
								seg       = SEG_READDR;
								bus_phase = T_START_SAMPLE;
							end else begin
								write_data();
							end
						end
						SEG_READDR: read_data();
						default:    write_data();
					endcase
				end
			end
			T_RD_LEAD: begin
				r.scl_out  = 1'b0;
				left_bytes = left_bytes - 1'b1;
				shifter    = '0;
				bit_pos    = 3'd7;
				bus_phase  = T_RD_HIGH;
			end
			T_RD_HIGH: begin
				shifter = {shifter[6:0], w.sda_in};
				if (bit_pos == 3'd0) begin
					r.rx_valid = 1'b1;
					r.rx_data  = shifter;
				end
				bus_phase = T_RD_LOW;
			end
			T_RD_LOW: begin
				r.scl_out = 1'b0;
				if (bit_pos == 3'd0) begin
					bus_phase = T_RA_SET;
				end else begin
					bit_pos   = bit_pos - 1'b1;
					bus_phase = T_RD_HIGH;
				end
			end
			T_RA_SET: begin
				r.scl_out = 1'b0;
				r.sda_out = ack_bit;
				bus_phase = T_RA_HIGH;
			end
			T_RA_HIGH: begin
				r.sda_out = ack_bit;
				bus_phase = T_RA_HOLD;
			end
			T_RA_HOLD: begin
				r.scl_out = 1'b0;
				r.sda_out = ack_bit;
				bus_phase = (left_bytes != 0) ? T_RD_LEAD : T_STOP_REL;
			end
			T_STOP_REL: begin
				r.scl_out = 1'b0;
				bus_phase = T_STOP_LOW;
			end
			T_STOP_LOW: begin
				r.scl_out = 1'b0;
				r.sda_out = 1'b0;
				bus_phase = T_STOP_CLK;
			end
			T_STOP_CLK: begin
				r.sda_out = 1'b0;
				bus_phase = T_STOP_END;
			end
			T_STOP_END: begin
				r.done_res = 1'b1;
				r.status   = nack_q ? i2cm_pkg::STATUS_NACK : i2cm_pkg::STATUS_GOOD;
				bus_phase  = T_IDLE;
			end
			default: begin
				bus_phase  = T_IDLE;
				r.busy_res = 1'b0;
				r.scl_out  = lines_q[1];
				r.sda_out  = lines_q[0];
			end
		endcase
		lines_q = {r.scl_out, r.sda_out};
		return r;
	endfunction

	// send one tick word and record its expected result once accepted
	task automatic send_word(i2cm_pkg::req_word_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (!req_ready);
		bus_words_due.push_back(bus_tick(w));
		words_sent++;
	endtask

	// word with no begin request, random elsewhere
	task automatic send_idle_word();
		i2cm_pkg::req_word_t w;
		w           = random_word();
		w.begin_req = 1'b0;
		send_word(w);
	endtask

	// one whole transaction; the target answers from the predicted phase.
	// busy_at picks which start sees a busy bus, nack_at which ack slot is NACKed
	task automatic run_transaction(logic [1:0] kind, logic [6:0] dev, logic [7:0] rg,
			logic [15:0] count, logic ack, int busy_at, int nack_at);
		i2cm_pkg::req_word_t w;
		bus_phase_t          upcoming;
		int                  starts;
		int                  acks;
		bit                  first;
		starts = 0;
		acks   = 0;
		first  = 1'b1;
		do begin
			w = random_word();
			if (first) begin
				w.begin_req   = 1'b1;
				w.kind        = kind;
				w.device_addr = dev;
				w.reg_addr    = rg;
				w.byte_count  = count;
				w.ack_level   = ack;
				upcoming      = T_START_SAMPLE;
			end else begin
				upcoming = bus_phase;
			end
			case (upcoming)
				T_START_SAMPLE: begin
					starts++;
					w.sda_in = (starts != busy_at);
				end
				T_ACK_SAMPLE: begin
					acks++;
					w.sda_in = (acks == nack_at);
				end
				default: ;
			endcase
			send_word(w);
			first = 1'b0;
		end while (bus_phase != T_IDLE);
	endtask

	// compare one field of a result word
	function automatic void field_check(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	// result side: random stalls, every accepted word checked against the oldest due
	initial begin
		int                  stall;
		i2cm_pkg::res_word_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			if (bus_words_due.size() == 0) begin
				$error("result word with none due");
				failures++;
			end else begin
				want = bus_words_due.pop_front();
				field_check("scl_out", want.scl_out, res_word.scl_out);
				field_check("sda_out", want.sda_out, res_word.sda_out);
				field_check("busy_res", want.busy_res, res_word.busy_res);
				field_check("byte_taken", want.byte_taken, res_word.byte_taken);
				field_check("rx_valid", want.rx_valid, res_word.rx_valid);
				field_check("rx_data", want.rx_data, res_word.rx_data);
				field_check("done_res", want.done_res, res_word.done_res);
				field_check("status", want.status, res_word.status);
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// idle ticks with begin low
	task automatic test_idle_noise();
		repeat (6) send_idle_word();
	endtask

	// plain writes, extreme addresses, zero byte count
	task automatic test_plain_write();
		run_transaction(i2cm_pkg::KIND_WRITE, 7'h7F, 8'h00, 16'd2, 1'b0, 0, 0);
		run_transaction(i2cm_pkg::KIND_WRITE, 7'h00, 8'hFF, 16'd0, 1'b1, 0, 0);
	endtask

	// plain reads with both ack levels, last byte always NACKed
	task automatic test_plain_read();
		calm = 1'b1;
		run_transaction(i2cm_pkg::KIND_READ, 7'h55, 8'h00, 16'd3, 1'b0, 0, 0);
		calm = 1'b0;
		run_transaction(i2cm_pkg::KIND_READ, 7'h2A, 8'hFF, 16'd2, 1'b1, 0, 0);
		run_transaction(i2cm_pkg::KIND_READ, 7'h7F, 8'h00, 16'd0, 1'b1, 0, 0);
	endtask

	task automatic test_register_write();
		run_transaction(i2cm_pkg::KIND_REG_WRITE, 7'h7F, 8'hFF, 16'd1, 1'b0, 0, 0);
		run_transaction(i2cm_pkg::KIND_REG_WRITE, 7'h01, 8'h00, 16'd0, 1'b1, 0, 0);
	endtask

	// register reads through the repeated start
	task automatic test_register_read();
		run_transaction(i2cm_pkg::KIND_REG_READ, 7'h00, 8'hA5, 16'd2, 1'b1, 0, 0);
		run_transaction(i2cm_pkg::KIND_REG_READ, 7'h7F, 8'h5A, 16'd1, 1'b0, 0, 0);
	endtask

	// busy bus at the first start and at the repeated start
	task automatic test_bus_busy();
		run_transaction(i2cm_pkg::KIND_WRITE, 7'h12, 8'h34, 16'hFFFF, 1'b1, 1, 0);
		run_transaction(i2cm_pkg::KIND_REG_READ, 7'h6C, 8'h80, 16'd2, 1'b0, 2, 0);
	endtask

	// NACK on address, register, second address and data bytes
	task automatic test_nack();
		run_transaction(i2cm_pkg::KIND_READ, 7'h7F, 8'h00, 16'hFFFF, 1'b1, 0, 1);
		run_transaction(i2cm_pkg::KIND_WRITE, 7'h33, 8'h00, 16'hFFFF, 1'b0, 0, 3);
		run_transaction(i2cm_pkg::KIND_REG_READ, 7'h40, 8'h0F, 16'd2, 1'b0, 0, 2);
		run_transaction(i2cm_pkg::KIND_REG_READ, 7'h21, 8'hF0, 16'd1, 1'b0, 0, 3);
		run_transaction(i2cm_pkg::KIND_REG_WRITE, 7'h0A, 8'h77, 16'd2, 1'b0, 0, 4);
	endtask

	// random transactions, mostly well formed, small counts, some noise between
	task automatic test_random();
		int unsigned stop_at;
		logic [1:0]  k;
		logic [15:0] n;
		int          slots;
		int          busy_at;
		int          nack_at;
		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at) begin
			calm = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(0, 2)) send_idle_word();
			k = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 24) == 0)
				n = 16'($urandom_range(256, 65535));
			else
				n = 16'($urandom_range(0, 3));
			case (k)
				i2cm_pkg::KIND_WRITE:     slots = 1 + n;
				i2cm_pkg::KIND_READ:      slots = 1;
				i2cm_pkg::KIND_REG_WRITE: slots = 2 + n;
				default:                  slots = 3;
			endcase
			busy_at = 0;
			if ($urandom_range(0, 9) == 0)
				busy_at = (k == i2cm_pkg::KIND_REG_READ) ? $urandom_range(1, 2) : 1;
			nack_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, slots) : 0;
			// long counts only run until the address is refused
			if (n > 16'd3)
				nack_at = 1;
			run_transaction(k, 7'($urandom), 8'($urandom), n, 1'($urandom), busy_at, nack_at);
		end
		calm = 1'b0;
	endtask

	// sequence of tests and final verdict
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_noise();
		test_plain_write();
		test_plain_read();
		test_register_write();
		test_register_read();
		test_bus_busy();
		test_nack();
		test_random();
		req_valid <= 1'b0;
		while (bus_words_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_transaction_engine.sv
rtl/i2cm_checker.sv
bench/testbench.sv
